// ===== rtl/rcls_pkg.sv =====
// Shared types, wheel wiring tables and modular helpers for the rotor cipher block.
package rcls_pkg;

   localparam int ALPHABET_SIZE       = 26;
   localparam int ASCII_A             = 65;
   localparam int ASCII_Z             = 90;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef logic [4:0] letter_type;
   typedef letter_type wire_tab_type [ALPHABET_SIZE];

   // One queued letter together with the wheel positions it is enciphered at.
   typedef struct packed {
      letter_type letter;
      letter_type fast_pos;
      letter_type middle_pos;
      letter_type slow_pos;
   } item_type;

   // Queue status seen by the front part and the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Entry wheel: QWERTZUIOASDFGHJKPYXCVBNML
   localparam wire_tab_type ENTRY_FWD = '{
      5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd25, 5'd20, 5'd8,  5'd14, 5'd0,
      5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd15, 5'd24, 5'd23,
      5'd2,  5'd21, 5'd1,  5'd13, 5'd12, 5'd11};
   // Fast wheel: JGDQOXUSCAMIFRVTPNEWKBLZYH
   localparam wire_tab_type FAST_FWD = '{
      5'd9,  5'd6,  5'd3,  5'd16, 5'd14, 5'd23, 5'd20, 5'd18, 5'd2,  5'd0,
      5'd12, 5'd8,  5'd5,  5'd17, 5'd21, 5'd19, 5'd15, 5'd13, 5'd4,  5'd22,
      5'd10, 5'd1,  5'd11, 5'd25, 5'd24, 5'd7};
   // Middle wheel: NTZPSFBOKMWRCJDIVLAEYUXHGQ
   localparam wire_tab_type MIDDLE_FWD = '{
      5'd13, 5'd19, 5'd25, 5'd15, 5'd18, 5'd5,  5'd1,  5'd14, 5'd10, 5'd12,
      5'd22, 5'd17, 5'd2,  5'd9,  5'd3,  5'd8,  5'd21, 5'd11, 5'd0,  5'd4,
      5'd24, 5'd20, 5'd23, 5'd7,  5'd6,  5'd16};
   // Slow wheel: JVIUBHTCDYAKEQZPOSGXNRMWFL
   localparam wire_tab_type SLOW_FWD = '{
      5'd9,  5'd21, 5'd8,  5'd20, 5'd1,  5'd7,  5'd19, 5'd2,  5'd3,  5'd24,
      5'd0,  5'd10, 5'd4,  5'd16, 5'd25, 5'd15, 5'd14, 5'd18, 5'd6,  5'd23,
      5'd13, 5'd17, 5'd12, 5'd22, 5'd5,  5'd11};
   // Reflector: QYHOGNECVPUZTFDJAXWMKISRBL
   localparam wire_tab_type REFLECT_FWD = '{
      5'd16, 5'd24, 5'd7,  5'd14, 5'd6,  5'd13, 5'd4,  5'd2,  5'd21, 5'd15,
      5'd20, 5'd25, 5'd19, 5'd5,  5'd3,  5'd9,  5'd0,  5'd23, 5'd22, 5'd12,
      5'd10, 5'd8,  5'd18, 5'd17, 5'd1,  5'd11};

   // Inverse wiring, built at elaboration. The lowest matching contact wins and
   // a contact that nothing maps to reads as zero.
   function automatic wire_tab_type invert_wiring(input wire_tab_type fwd);
      wire_tab_type inv;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         inv[i] = '0;
      end
      for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
         inv[fwd[i]] = letter_type'(i);
      end
      return inv;
   endfunction

   localparam wire_tab_type ENTRY_INV  = invert_wiring(ENTRY_FWD);
   localparam wire_tab_type FAST_INV   = invert_wiring(FAST_FWD);
   localparam wire_tab_type MIDDLE_INV = invert_wiring(MIDDLE_FWD);
   localparam wire_tab_type SLOW_INV   = invert_wiring(SLOW_FWD);

   // (a - k) mod 26 for a and k both below 26.
   function automatic letter_type mod_sub(input letter_type a, input letter_type k);
      logic [5:0] s;
      s = {1'b0, a} + 6'(ALPHABET_SIZE) - {1'b0, k};
      if (s >= 6'(ALPHABET_SIZE)) begin
         s = s - 6'(ALPHABET_SIZE);
      end
      return s[4:0];
   endfunction

   // (a + k) mod 26 for a and k both below 26.
   function automatic letter_type mod_add(input letter_type a, input letter_type k);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, k};
      if (s >= 6'(ALPHABET_SIZE)) begin
         s = s - 6'(ALPHABET_SIZE);
      end
      return s[4:0];
   endfunction

   function automatic letter_type rot_fwd(input wire_tab_type tab, input letter_type pos,
                                          input letter_type i);
      return tab[mod_sub(i, pos)];
   endfunction

   function automatic letter_type rot_inv(input wire_tab_type inv, input letter_type pos,
                                          input letter_type c);
      return mod_add(inv[c], pos);
   endfunction

   // Next position of a wheel, wrapping after the last letter.
   function automatic letter_type wheel_next(input letter_type pos);
      letter_type r;
      if (pos == letter_type'(ALPHABET_SIZE - 1)) begin
         r = '0;
      end else begin
         r = pos + 5'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/rcls_front.sv =====
// Front part: accepts bytes, drops non-letters and stamps each letter with the wheel positions.
module rcls_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  rcls_pkg::qstat_type qstat,
   output logic               push,
   output rcls_pkg::item_type push_item
);
   import rcls_pkg::*;

   letter_type fast_ff, fast_in;
   letter_type middle_ff, middle_in;
   letter_type slow_ff, slow_in;
   logic       is_letter;
   logic       accept;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_letter  = (req_tdata >= 8'(ASCII_A)) && (req_tdata <= 8'(ASCII_Z));
   assign push       = accept && is_letter;

   always_comb begin
      push_item.letter     = letter_type'(req_tdata - 8'(ASCII_A));
      push_item.fast_pos   = fast_ff;
      push_item.middle_pos = middle_ff;
      push_item.slow_pos   = slow_ff;
   end

   // The fast wheel steps on every letter; a wrap carries into the next wheel.
   always_comb begin
      fast_in   = fast_ff;
      middle_in = middle_ff;
      slow_in   = slow_ff;
      if (push) begin
         fast_in = wheel_next(fast_ff);
         if (fast_ff == letter_type'(ALPHABET_SIZE - 1)) begin
            middle_in = wheel_next(middle_ff);
            if (middle_ff == letter_type'(ALPHABET_SIZE - 1)) begin
               slow_in = wheel_next(slow_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff   <= '0;
         middle_ff <= '0;
         slow_ff   <= '0;
      end else begin
         fast_ff   <= fast_in;
         middle_ff <= middle_in;
         slow_ff   <= slow_in;
      end
   end

endmodule

// ===== rtl/rcls_queue.sv =====
// Short first-in first-out queue of stamped letters between the front and back parts.
module rcls_queue #(
   parameter int QUEUE_DEPTH = rcls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  rcls_pkg::item_type               push_item,
   input  logic                             pop,
   output rcls_pkg::item_type               head_item,
   output rcls_pkg::qstat_type              qstat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill
);
   import rcls_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign qstat.full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_item   = slots_ff[rd_ptr_ff];
   assign fill        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rcls_back.sv =====
// Back part: three-stage wiring pipeline ending in the result register.
module rcls_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  rcls_pkg::item_type head_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata
);
   import rcls_pkg::*;

   typedef struct packed {
      letter_type value;
      letter_type fast_pos;
      letter_type middle_pos;
      letter_type slow_pos;
   } stage_type;

   logic       advance;
   logic       s1_valid_ff, s2_valid_ff, out_valid_ff;
   stage_type  s1_ff, s1_in;
   stage_type  s2_ff, s2_in;
   logic [6:0] out_letter_ff, out_letter_in;
   letter_type v_a, v_b, v_c, v_d, v_e, v_f;

   // The whole pipeline moves together whenever the result register is free.
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && head_valid;

   // Stage one: entry wheel, then the fast and middle wheels forward.
   always_comb begin
      v_a               = ENTRY_FWD[head_item.letter];
      v_b               = rot_fwd(FAST_FWD, head_item.fast_pos, v_a);
      s1_in.value       = rot_fwd(MIDDLE_FWD, head_item.middle_pos, v_b);
      s1_in.fast_pos    = head_item.fast_pos;
      s1_in.middle_pos  = head_item.middle_pos;
      s1_in.slow_pos    = head_item.slow_pos;
   end

   // Stage two: slow wheel forward, reflector, slow wheel back.
   always_comb begin
      v_c              = rot_fwd(SLOW_FWD, s1_ff.slow_pos, s1_ff.value);
      v_d              = REFLECT_FWD[v_c];
      s2_in.value      = rot_inv(SLOW_INV, s1_ff.slow_pos, v_d);
      s2_in.fast_pos   = s1_ff.fast_pos;
      s2_in.middle_pos = s1_ff.middle_pos;
      s2_in.slow_pos   = s1_ff.slow_pos;
   end

   // Stage three: middle and fast wheels back, entry wheel back, to ASCII.
   always_comb begin
      v_e           = rot_inv(MIDDLE_INV, s2_ff.middle_pos, s2_ff.value);
      v_f           = rot_inv(FAST_INV, s2_ff.fast_pos, v_e);
      out_letter_in = 7'(ASCII_A) + {2'b00, ENTRY_INV[v_f]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         out_letter_ff <= out_letter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_letter_ff};

endmodule

// ===== rtl/rotor_cipher_letter_step.sv =====
// Top level of the three-rotor letter cipher: front, queue and back parts joined.
//
// Usage. Bytes arrive one per beat on the req_ stream. A byte that is an ASCII
// capital letter is enciphered and gives exactly one beat on the rsp_ stream,
// holding the enciphered capital letter; any other byte is accepted and
// dropped without touching the wheels. Results leave in the order their
// letters arrived.
// The front part filters the byte, stamps it with the current wheel positions
// and steps the wheels, so the wheel state never waits on the wiring logic.
// Stamped letters wait in a short queue of QUEUE_DEPTH entries. The back part
// runs the wiring in three register stages, the last of which is the output
// register.
// Throughput is one byte per cycle in steady state, while the receiver is ready. With
// an empty queue and the receiver ready, a letter passes from the queue through the
// two wiring stages into the output register, where its result beat is offered.
// When the receiver stalls, the back pipeline holds, the queue fills and
// req_tready falls only once the queue is full; the pipeline stages and the
// queue together buffer the beats in flight, so nothing is lost or repeated.
// Synchronous reset returns all three wheels to position zero and empties the
// queue and the pipeline; there is no clearing pass.
module rotor_cipher_letter_step #(
   parameter int QUEUE_DEPTH = rcls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] out_letter, [7] zero
);
   import rcls_pkg::*;

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic               push;
   item_type           push_item;
   logic               pop;
   item_type           head_item;
   qstat_type          qstat;
   logic [COUNT_W-1:0] fill;

   // Front part: classification and wheel stepping.
   rcls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   // Decoupling queue between the two parts.
   rcls_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat),
      .fill      (fill)
   );

   // Back part: the wiring pipeline and the output register.
   rcls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!qstat.empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The fill count never exceeds the depth, and agrees with the empty flag.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      (fill <= COUNT_W'(QUEUE_DEPTH)) && (qstat.empty == (fill == '0)))
      else $error("queue fill count out of step");

   // A letter queued while nothing leaves grows the fill count by one.
   a_fill_grows : assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill == $past(fill) + 1'b1)
      else $error("queued letter lost");

   // Every result beat carries a capital letter.
   a_out_letter : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'(ASCII_A)) && (rsp_tdata <= 8'(ASCII_Z)))
      else $error("result is not a capital letter");

   // Straight after reset no result is offered.
   a_reset_quiet : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

// ===== bench/rcls_checker.sv =====
// Checker for the rotor cipher block: watches both streams, predicts each result and compares.
module rcls_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [6:0] out_letter, [7] zero
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import rcls_pkg::letter_type;

   localparam int LETTERS     = rcls_pkg::ALPHABET_SIZE;
   localparam int WHEEL_COUNT = 5;

   typedef enum int {
      WHL_ENTRY,
      WHL_FAST,
      WHL_MIDDLE,
      WHL_SLOW,
      WHL_REFLECT
   } wheel_id_type;

   letter_type wiring_fwd [WHEEL_COUNT][LETTERS];
   letter_type wiring_inv [WHEEL_COUNT][LETTERS];
   letter_type fast_pos;
   letter_type middle_pos;
   letter_type slow_pos;
   logic [6:0] cipher_queue [$];

   // Fills the forward table of one wheel from its spelling, then the inverse by search;
   // where two contacts share a letter the lowest one is kept.
   task automatic load_wheel(input wheel_id_type w, input string spelling);
      for (int i = 0; i < LETTERS; i++) begin
         wiring_fwd[w][i] = letter_type'(int'(spelling[i]) - rcls_pkg::ASCII_A);
      end
      for (int c = 0; c < LETTERS; c++) begin
         wiring_inv[w][c] = '0;
         for (int i = LETTERS - 1; i >= 0; i--) begin
            if (int'(wiring_fwd[w][i]) == c) begin
               wiring_inv[w][c] = letter_type'(i);
            end
         end
      end
   endtask

   function automatic letter_type rotor_in(input wheel_id_type w, input letter_type pos,
                                           input letter_type i);
      return wiring_fwd[w][(int'(i) + LETTERS - int'(pos)) % LETTERS];
   endfunction

   function automatic letter_type rotor_out(input wheel_id_type w, input letter_type pos,
                                            input letter_type c);
      return letter_type'((int'(wiring_inv[w][c]) + int'(pos)) % LETTERS);
   endfunction

   // Enciphers one capital letter at the present wheel positions.
   function automatic logic [6:0] encipher(input logic [7:0] in_byte);
      letter_type v;
      v = letter_type'(int'(in_byte) - rcls_pkg::ASCII_A);
      v = wiring_fwd[WHL_ENTRY][v];
      v = rotor_in(WHL_FAST, fast_pos, v);
      v = rotor_in(WHL_MIDDLE, middle_pos, v);
      v = rotor_in(WHL_SLOW, slow_pos, v);
      v = wiring_fwd[WHL_REFLECT][v];
      v = rotor_out(WHL_SLOW, slow_pos, v);
      v = rotor_out(WHL_MIDDLE, middle_pos, v);
      v = rotor_out(WHL_FAST, fast_pos, v);
      v = wiring_inv[WHL_ENTRY][v];
      return 7'(int'(v) + rcls_pkg::ASCII_A);
   endfunction

   task automatic report_failure(input string what);
      $display("[%0t] result beat %0d: %s", $realtime, checked_count, what);
      fail_count++;
   endtask

   initial begin
      load_wheel(WHL_ENTRY,   "QWERTZUIOASDFGHJKPYXCVBNML");
      load_wheel(WHL_FAST,    "JGDQOXUSCAMIFRVTPNEWKBLZYH");
      load_wheel(WHL_MIDDLE,  "NTZPSFBOKMWRCJDIVLAEYUXHGQ");
      load_wheel(WHL_SLOW,    "JVIUBHTCDYAKEQZPOSGXNRMWFL");
      load_wheel(WHL_REFLECT, "QYHOGNECVPUZTFDJAXWMKISRBL");
   end

   always @(posedge clock) begin : watch
      logic [6:0] want;
      if (reset) begin
         fast_pos      = '0;
         middle_pos    = '0;
         slow_pos      = '0;
         fail_count    = 0;
         checked_count = 0;
         cipher_queue.delete();
      end else begin
         // Results are taken first, so a letter accepted at this edge cannot match them.
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_queue.size() == 0) begin
               report_failure($sformatf("beat 0x%02h arrived with no letter outstanding",
                                        rsp_tdata));
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_tdata[6:0] !== want) begin
                  report_failure($sformatf("out_letter is 0x%02h, expected 0x%02h",
                                           rsp_tdata[6:0], want));
               end
               if (rsp_tdata[7] !== 1'b0) begin
                  report_failure("pad bit 7 of rsp_tdata is not zero");
               end
            end
            checked_count++;
         end
         if (req_tvalid && req_tready && req_tdata >= 8'(rcls_pkg::ASCII_A)
             && req_tdata <= 8'(rcls_pkg::ASCII_Z)) begin
            cipher_queue.push_back(encipher(req_tdata));
            if (int'(fast_pos) == LETTERS - 1) begin
               fast_pos = '0;
               if (int'(middle_pos) == LETTERS - 1) begin
                  middle_pos = '0;
                  slow_pos   = (int'(slow_pos) == LETTERS - 1) ? '0 : slow_pos + 5'd1;
               end else begin
                  middle_pos = middle_pos + 5'd1;
               end
            end else begin
               fast_pos = fast_pos + 5'd1;
            end
         end
      end
      pending_count = cipher_queue.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the bench for the rotor cipher block: clock, reset, stimulus and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcls_pkg::ALPHABET_SIZE;
   import rcls_pkg::ASCII_A;
   import rcls_pkg::ASCII_Z;

   // The limit is many times the length of the slowest correct run.
   localparam int CYCLE_LIMIT      = 400000;
   // Comfortably more than a letter takes to pass the queue and the pipeline.
   localparam int DRAIN_CYCLES     = 16;
   localparam int RANDOM_PER_PHASE = 480;
   localparam int DIRECTED_COUNT   = 24;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [6:0] out_letter, [7] zero

   int fail_count;
   int pending_count;
   int checked_count;
   int tx_idle_pct;
   int rx_idle_pct;
   int letters_sent;
   int others_sent;
   int cycle_count;

   // The boundaries of the letter range on both sides, lower case, the top bit set on
   // otherwise capital codes, the extremes of the byte, and a few repeated letters so
   // that the same plain letter is seen to encipher differently as the fast wheel steps.
   logic [7:0] directed_bytes [DIRECTED_COUNT] = '{
      8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61,
      8'h7A, 8'h7B, 8'h7F, 8'h80, 8'hC1, 8'hDA, 8'h0A, 8'h20,
      8'h41, 8'h41, 8'h41, 8'h5A, 8'h5A, 8'h4D, 8'h4E, 8'h55};

   rotor_cipher_letter_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rcls_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Guard against a hang: the run is abandoned once the cycle count passes the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run abandoned after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver decides afresh at every falling edge whether it will take a beat,
   // so its stalls land on every stage of the block's pipeline and queue.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offers one byte and returns at the falling edge after it has been accepted. The
   // task is entered at a falling edge and makes at most one assignment to the valid
   // per edge, so a valid that stays high across back-to-back beats never dips.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      @(negedge clock);
      if (b >= 8'(ASCII_A) && b <= 8'(ASCII_Z)) begin
         letters_sent++;
      end else begin
         others_sent++;
      end
   endtask

   // Mostly capital letters, which are what reach the wiring and step the wheels;
   // the rest are bytes from the whole range, letters among them by chance.
   task automatic run_random(input int count);
      logic [7:0] b;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 80) begin
            b = 8'(ASCII_A + $urandom_range(ALPHABET_SIZE - 1));
         end else begin
            b = 8'($urandom_range(255));
         end
         send_byte(b);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      tx_idle_pct  = 25;
      rx_idle_pct  = 71;
      letters_sent = 0;
      others_sent  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First phase: a sender that pauses now and then against a receiver that stalls
      // most of the time, so the queue fills and req_tready falls.
      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i]);
      end
      run_random(RANDOM_PER_PHASE);

      // Second phase: a sparse sender against a mostly ready receiver.
      tx_idle_pct = 71;
      rx_idle_pct = 25;
      run_random(RANDOM_PER_PHASE);

      // Third phase: no idling on either side, one beat per cycle.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      req_tvalid <= 1'b0;

      // Wait for the last results, then a while longer for any stray beat to show.
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Offered %0d capital letters and %0d other bytes; %0d result beats checked.",
               letters_sent, others_sent, checked_count);
      $display("The fast and middle wheels wrapped; stalls on both sides varied by phase.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
